/* hw/rtl/owh_pkg.sv */
// Package for the one-at-a-time word hash core: payload structs,
// register map, hash constants and the divider request/response types.
// No dependencies.
`timescale 1ns / 1ps

package owh_pkg;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned BCOUNT_W = 25;
  localparam int unsigned BIDX_W   = 24;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // Register index, taken from paddr[ADDR_W-1:2]
  localparam logic REG_BUCKET_COUNT = 1'b0;

  localparam logic [BCOUNT_W-1:0] BUCKET_COUNT_RESET = BCOUNT_W'(1024);
  localparam logic [BCOUNT_W-1:0] MAX_BUCKETS        = BCOUNT_W'(16777216);

  // Shift amounts of the mixing and finalizing steps
  localparam int unsigned MIX_SHL = 10;
  localparam int unsigned MIX_SHR = 6;
  localparam int unsigned FIN_SHL_A = 3;
  localparam int unsigned FIN_SHR   = 11;
  localparam int unsigned FIN_SHL_B = 15;

  localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              has_char;
    logic              word_end;
  } in_t;

  typedef struct packed {
    logic [HASH_W-1:0] word_hash;
    logic [BIDX_W-1:0] bucket_index;
  } out_t;

  typedef struct packed {
    logic                start;
    logic [HASH_W-1:0]   dividend;
    logic [BCOUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [BIDX_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* hw/rtl/oaat_word_hash_bucket_index_core.sv */
// Top level of the one-at-a-time word hash core: APB register, input and
// output channels, step sequencer around one shared add/xor-shift unit.
// Depends on owh_pkg and owh_div.
// Sequence: an ending character transaction runs 3 mixing steps, 3 finalizing steps, the
// remainder run and the output load before out_valid rises; a bare end marker skips the
// mixing steps. An idle transaction leaves in_ready high; any other transaction holds
// in_ready low until its steps or its result load are done; a stalled output slot adds its wait.
// Synchronous active-high reset clears the running hash, the sequencer and
// the output valid, and sets bucket_count to 1024.
`timescale 1ns / 1ps

module oaat_word_hash_bucket_index_core
  import owh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MIX  = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [1:0]          step;
  logic [BCOUNT_W-1:0] bucket_count;
  logic [HASH_W-1:0]   running_hash;
  logic [HASH_W-1:0]   alu_b;
  logic [HASH_W-1:0]   alu_out;
  logic                alu_xor;
  logic [CHAR_W-1:0]   chr;
  logic [CHAR_W-1:0]   chr_low;
  logic                end_q;
  logic [BIDX_W-1:0]   bidx;
  logic                in_fire;
  logic                out_load;
  logic                step_last;
  logic                reg_sel;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_BUCKET_COUNT);
  assign prdata  = reg_sel ? DATA_W'(bucket_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      bucket_count <= pwdata[BCOUNT_W-1:0];
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);
  assign step_last = (step == 2'd2);

  // Fold upper case ASCII letters
  assign chr_low = ((in_data.char_byte >= UPPER_A) && (in_data.char_byte <= UPPER_Z))
                 ? in_data.char_byte + CASE_DELTA : in_data.char_byte;

  // Shared unit: h <= h + b or h <= h ^ b, b picked by state and step
  always_comb begin
    alu_b   = '0;
    alu_xor = 1'b0;
    if (state == ST_MIX) begin
      case (step)
        2'd0:    alu_b = HASH_W'(chr);
        2'd1:    alu_b = running_hash << MIX_SHL;
        default: begin
          alu_b   = running_hash >> MIX_SHR;
          alu_xor = 1'b1;
        end
      endcase
    end else begin
      case (step)
        2'd0:    alu_b = running_hash << FIN_SHL_A;
        2'd1: begin
          alu_b   = running_hash >> FIN_SHR;
          alu_xor = 1'b1;
        end
        default: alu_b = running_hash << FIN_SHL_B;
      endcase
    end
    alu_out = alu_xor ? (running_hash ^ alu_b) : (running_hash + alu_b);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.has_char) begin
            state_next = ST_MIX;
          end else if (in_data.word_end) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_MIX: begin
        if (step_last) begin
          state_next = end_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (step_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_MIX) || (state == ST_FIN)) begin
        running_hash <= alu_out;
        step         <= step_last ? 2'd0 : step + 2'd1;
      end
      if (out_load) begin
        running_hash <= '0;
        out_valid    <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      chr   <= chr_low;
      end_q <= in_data.word_end;
    end
    if (div_rsp.done) begin
      bidx <= div_rsp.remainder;
    end
    if (out_load) begin
      out_data.word_hash    <= running_hash;
      out_data.bucket_index <= bidx;
    end
  end

  // Start the remainder on the last finalizing step; clamp the divisor
  assign div_req.start    = (state == ST_FIN) && step_last;
  assign div_req.dividend = alu_out;
  assign div_req.divisor  = (bucket_count > MAX_BUCKETS) ? MAX_BUCKETS : bucket_count;

  owh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  a_char_mixes : assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.has_char) |=> (state == ST_MIX) && (step == 2'd0))
    else $error("character transaction not mixed");

  a_hash_cleared : assert property (@(posedge clk) disable iff (rst)
    out_load |=> (running_hash == '0) && out_valid)
    else $error("running hash not cleared after result");

  a_div_only_in_div : assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("remainder arrived outside divide phase");

  a_idle_after_bare : assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_data.has_char && !in_data.word_end) |=> in_ready)
    else $error("idle transaction left the sequencer busy");

endmodule

/* hw/rtl/owh_div.sv */
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on owh_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module owh_div
  import owh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(HASH_W);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    count;
  logic [HASH_W-1:0]   dividend;
  logic [BCOUNT_W-1:0] divisor;
  logic [BCOUNT_W-1:0] rem;
  logic [BCOUNT_W:0]   shifted;
  logic                fits;

  assign shifted = {rem, dividend[HASH_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      dividend <= {dividend[HASH_W-2:0], 1'b0};
      // A zero divisor yields a zero remainder
      if (divisor == '0) begin
        rem <= '0;
      end else if (fits) begin
        rem <= BCOUNT_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[BCOUNT_W-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem[BIDX_W-1:0];

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy)
    else $error("divider did not start");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a run");

  a_rem_below_div : assert property (@(posedge clk) disable iff (rst)
    done |-> (divisor == '0) || (rem < divisor))
    else $error("remainder not below divisor");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the one-at-a-time word hash core.
// Runs words through the valid/ready channels, mostly under random stalls, predicts each hash
// and its bucket, and reprograms bucket_count over APB between phases. Needs owh_pkg.
`timescale 1ns / 1ps

module tb;
  import owh_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned NUM_SETTINGS    = 7;
  localparam int unsigned LARGEST_TABLE   = 16777216;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  in_t                 char_stream[$];
  out_t                hashes_due[$];
  logic [HASH_W-1:0]   partial_hash = '0;
  logic [BCOUNT_W-1:0] table_size   = BUCKET_COUNT_RESET;
  logic                no_stalls    = 1'b0;
  int unsigned         cycles        = 0;
  int unsigned         mismatches    = 0;
  int unsigned         queued_items  = 0;
  int unsigned         words_checked = 0;

  oaat_word_hash_bucket_index_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] absorb_char(logic [HASH_W-1:0] h,
                                                     logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] folded;
    folded = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    h = h + HASH_W'(folded);
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  function automatic logic [HASH_W-1:0] finish_hash(logic [HASH_W-1:0] h);
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  function automatic logic [BIDX_W-1:0] bucket_of(logic [HASH_W-1:0] h,
                                                   logic [BCOUNT_W-1:0] count);
    logic [31:0] divisor;
    divisor = (32'(count) > LARGEST_TABLE) ? LARGEST_TABLE : 32'(count);
    if (divisor == 0) return '0;
    return BIDX_W'(h % divisor);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return CHAR_W'($urandom_range(8'h41, 8'h5A));
    if (r < 7) return CHAR_W'($urandom_range(8'h61, 8'h7A));
    return CHAR_W'($urandom);
  endfunction

  task automatic log_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d on %s: expected %h, got %h", mismatches, what, want, got);
  endtask

  task automatic push_char(logic [CHAR_W-1:0] c, logic has_char, logic word_end);
    in_t t;
    t.char_byte = c;
    t.has_char  = has_char;
    t.word_end  = word_end;
    char_stream.push_back(t);
    if (has_char || word_end) queued_items++;
  endtask

  // Mostly well-formed words with random content, some noise bursts in between.
  task automatic queue_random_words(int unsigned quota);
    int unsigned first;
    int unsigned len;
    first = queued_items;
    while (queued_items - first < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          push_char(CHAR_W'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 30);
        repeat (len) begin
          if ($urandom_range(0, 19) == 0) push_char(CHAR_W'($urandom), 1'b0, 1'b0);
          push_char(pick_char(), 1'b1, 1'b0);
        end
        if ($urandom_range(0, 1) == 1) push_char(pick_char(), 1'b1, 1'b1);
        else push_char(CHAR_W'($urandom), 1'b0, 1'b1);
      end
    end
  endtask

  task automatic write_bucket_count(logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BUCKET_COUNT, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    table_size = value[BCOUNT_W-1:0];
  endtask

  // Wait for the last hash, then give trailing characters time to finish mixing.
  task automatic wait_drained();
    while (char_stream.size() != 0 || in_valid || hashes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: predict on every accepted transaction, then load the next one.
  always @(posedge clk) begin
    out_t due;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.has_char) partial_hash = absorb_char(partial_hash, in_data.char_byte);
        if (in_data.word_end) begin
          due.word_hash    = finish_hash(partial_hash);
          due.bucket_index = bucket_of(due.word_hash, table_size);
          hashes_due.push_back(due);
          partial_hash = '0;
        end
      end
      if (!in_valid || in_ready) begin
        if (char_stream.size() != 0 && (no_stalls || $urandom_range(0, 99) >= 32)) begin
          in_valid <= 1'b1;
          in_data  <= char_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_stalls || ($urandom_range(0, 99) >= 32);
      if (out_valid && out_ready) begin
        if (hashes_due.size() == 0) begin
          log_mismatch("unexpected result", 64'd0, 64'(out_data));
        end else begin
          want = hashes_due.pop_front();
          words_checked++;
          if (out_data.word_hash !== want.word_hash)
            log_mismatch("word_hash", 64'(want.word_hash), 64'(out_data.word_hash));
          if (out_data.bucket_index !== want.bucket_index)
            log_mismatch("bucket_index", 64'(want.bucket_index), 64'(out_data.bucket_index));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d hashes still due", cycles, hashes_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] settings [NUM_SETTINGS];
    settings[0] = 32'd1;
    settings[1] = 32'd16777216;
    settings[2] = 32'd0;
    settings[3] = 32'hFFFF_FFFF;
    settings[4] = 32'd7;
    settings[5] = DATA_W'($urandom_range(2, 16777215));
    settings[6] = 32'd16777215;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty word, ending items with and without a character, case-fold edges, idles.
    push_char(8'h00, 1'b0, 1'b1);
    push_char(8'h41, 1'b1, 1'b0);
    push_char(8'h5A, 1'b1, 1'b1);
    push_char(8'h40, 1'b1, 1'b0);
    push_char(8'h00, 1'b0, 1'b0);
    push_char(8'h5B, 1'b1, 1'b0);
    push_char(8'h60, 1'b1, 1'b0);
    push_char(8'h7B, 1'b1, 1'b0);
    push_char(8'hFF, 1'b1, 1'b0);
    push_char(8'h00, 1'b1, 1'b0);
    push_char(8'hFF, 1'b0, 1'b0);
    push_char(8'h61, 1'b1, 1'b0);
    push_char(8'h7A, 1'b1, 1'b0);
    push_char(8'hAA, 1'b0, 1'b1);
    push_char(8'hFF, 1'b1, 1'b1);
    push_char(8'h55, 1'b0, 1'b1);
    queue_random_words(ITEMS_PER_PHASE);
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      no_stalls <= (p == 3);
      write_bucket_count(settings[p]);
      queue_random_words(ITEMS_PER_PHASE);
      wait_drained();
    end

    $display("hashed %0d words from %0d transactions under %0d bucket counts",
             words_checked, queued_items, NUM_SETTINGS + 1);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
